@@ src/spdt_pkg.sv @@
// shared types, constants and saturating arithmetic for the shock point dependence test
package spdt_pkg;

    localparam int DW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int SQRT_LAT  = DW;          // one root bit per stage
    localparam int DT_W      = DW - 1;      // dt and other non-negative words
    localparam int DD_W      = DT_W + 8;    // den * 100
    localparam int NUM_W     = DT_W + FRAC_BITS + 1;
    localparam int DIV_LAT   = DT_W + 1;    // overflow check plus one quotient bit per stage
    localparam int PIPE_LAT  = 3 + SQRT_LAT + 2 + DIV_LAT + 6 + SQRT_LAT + 1;

    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic [6:0] DT_SCALE = 7'd100;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] ush;
        logic signed [DW-1:0] vsh;
        logic signed [DW-1:0] xi;
        logic signed [DW-1:0] yi;
        logic signed [DW-1:0] ui;
        logic signed [DW-1:0] vi;
        logic [DT_W-1:0]      ai;
    } t_pt;

    function automatic logic signed [DW-1:0] sat_w(input logic signed [DW:0] v);
        if (v > $signed({1'b0, MAXV})) begin
            return MAXV;
        end else if (v < $signed({1'b1, MINV})) begin
            return MINV;
        end
        return v[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        return sat_w({a[DW-1], a} + {b[DW-1], b});
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        return sat_w({a[DW-1], a} - {b[DW-1], b});
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
        return a[DW-1] ? DW'(-a) : a;
    endfunction

    function automatic logic [DT_W-1:0] clamp_root(input logic [DW-1:0] r);
        return r[DW-1] ? {DT_W{1'b1}} : r[DT_W-1:0];
    endfunction

    // round to nearest, ties away from zero, then saturate
    function automatic logic signed [DW-1:0] qround(input logic [DW+DT_W-1:0] p,
                                                    input logic neg);
        logic [DW+DT_W:0]         t;
        logic [DW+DT_W-FRAC_BITS:0] s;
        t = {1'b0, p} + ((DW+DT_W+1)'(1) << (FRAC_BITS - 1));
        s = t[DW+DT_W:FRAC_BITS];
        if (s[DW+DT_W-FRAC_BITS:DT_W] != '0) begin
            return neg ? MINV : MAXV;
        end
        return neg ? DW'(-$signed({1'b0, s[DT_W-1:0]})) : DW'({1'b0, s[DT_W-1:0]});
    endfunction

endpackage

@@ src/spdt_sqrt.sv @@
// pipelined integer square root, one root bit per stage
module spdt_sqrt import spdt_pkg::*; (
    input  logic                i_clk,
    input  logic [2*DW-1:0]     i_rad,
    output logic [DW-1:0]       o_root
);

    logic [2*DW-1:0] r_rad  [SQRT_LAT];
    logic [DW+1:0]   r_rem  [SQRT_LAT];
    logic [DW-1:0]   r_root [SQRT_LAT];

    genvar k;
    generate
        for (k = 0; k < SQRT_LAT; k++) begin : g_stage
            logic [2*DW-1:0] w_rad;
            logic [DW+1:0]   w_rem;
            logic [DW-1:0]   w_root;
            logic [DW+3:0]   n_sh;
            logic [DW+3:0]   n_tr;

            if (k == 0) begin : g_first
                assign w_rad  = i_rad;
                assign w_rem  = '0;
                assign w_root = '0;
            end else begin : g_next
                assign w_rad  = r_rad[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_root = r_root[k-1];
            end

            always_comb begin
                n_sh = {w_rem, w_rad[2*DW-1:2*DW-2]};
                n_tr = {2'b00, w_root, 2'b01};
            end

            always_ff @(posedge i_clk) begin
                r_rad[k] <= {w_rad[2*DW-3:0], 2'b00};
                if (n_sh >= n_tr) begin
                    r_rem[k]  <= DW'(n_sh - n_tr) | ((DW+2)'(n_sh - n_tr) & {2'b11, {DW{1'b0}}});
                    r_root[k] <= {w_root[DW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_sh[DW+1:0];
                    r_root[k] <= {w_root[DW-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_root = r_root[SQRT_LAT-1];

endmodule

@@ src/spdt_div.sv @@
// pipelined restoring divider with a saturating quotient
module spdt_div import spdt_pkg::*; (
    input  logic               i_clk,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DD_W-1:0]    i_den,
    output logic [DT_W-1:0]    o_quo
);

    logic [DD_W-1:0] r_rem [DIV_LAT];
    logic [DD_W-1:0] r_den [DIV_LAT];
    logic [DT_W-1:0] r_low [DIV_LAT];
    logic [DT_W-1:0] r_quo [DIV_LAT];
    logic            r_sat [DIV_LAT];

    // quotient of 2^31 or more saturates: test the top bits against the divisor first
    always_ff @(posedge i_clk) begin
        r_rem[0] <= DD_W'(i_num[NUM_W-1:DT_W]);
        r_sat[0] <= DD_W'(i_num[NUM_W-1:DT_W]) >= i_den;
        r_den[0] <= i_den;
        r_low[0] <= i_num[DT_W-1:0];
        r_quo[0] <= '0;
    end

    genvar k;
    generate
        for (k = 1; k < DIV_LAT; k++) begin : g_stage
            logic [DD_W:0] n_sh;
            logic [DD_W:0] n_diff;

            always_comb begin
                n_sh   = {r_rem[k-1], r_low[k-1][DT_W-1]};
                n_diff = n_sh - {1'b0, r_den[k-1]};
            end

            always_ff @(posedge i_clk) begin
                r_den[k] <= r_den[k-1];
                r_sat[k] <= r_sat[k-1];
                r_low[k] <= {r_low[k-1][DT_W-2:0], 1'b0};
                if (n_sh >= {1'b0, r_den[k-1]}) begin
                    r_rem[k] <= n_diff[DD_W-1:0];
                    r_quo[k] <= {r_quo[k-1][DT_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= n_sh[DD_W-1:0];
                    r_quo[k] <= {r_quo[k-1][DT_W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_quo = r_sat[DIV_LAT-1] ? {DT_W{1'b1}} : r_quo[DIV_LAT-1];

endmodule

@@ src/shock_point_dependence_test.sv @@
// shock point dependence test: top level pipeline
//
// One transaction carries a shock point (position, velocity) and a grid point
// (position, flow velocity, sound speed), all Q16.16. start with busy low
// accepts it. busy is always low: the pipeline takes a new transaction every
// clock cycle and never holds one off.
// Each transaction yields one result on o_dependent and o_zero_speed_fault,
// valid for the single cycle in which o_done is high. Results leave in the
// order the transactions came in.
// The pipeline length is set by the two 32-stage square root pipelines
// (distance and advanced distance) and the 32-stage divider that forms the
// time step.
// Throughput: one transaction per cycle.
// Reset (synchronous, active low) clears every valid bit, so results of
// transactions still in flight are dropped; data registers are not cleared.
// The receiver cannot stall; it must take each result in its strobe cycle.
module shock_point_dependence_test import spdt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [DW-1:0]  i_shock_x,
    input  logic signed [DW-1:0]  i_shock_y,
    input  logic signed [DW-1:0]  i_shock_vel_x,
    input  logic signed [DW-1:0]  i_shock_vel_y,
    input  logic signed [DW-1:0]  i_grid_x,
    input  logic signed [DW-1:0]  i_grid_y,
    input  logic signed [DW-1:0]  i_grid_vel_x,
    input  logic signed [DW-1:0]  i_grid_vel_y,
    input  logic [DT_W-1:0]       i_sound_speed,
    output logic                  o_done,
    output logic                  o_dependent,
    output logic                  o_zero_speed_fault
);

    typedef struct packed {
        t_pt             pt;
        logic [DT_W-1:0] rl;
        logic            zero;
    } t_mid;

    typedef struct packed {
        logic [DT_W-1:0]      rl;
        logic signed [DW-1:0] pa;
        logic                 zero;
    } t_tail;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage a: differences
    logic                 r_a_vld;
    t_pt                  r_a_pt;
    logic signed [DW-1:0] r_a_dx, r_a_dy;
    t_pt                  n_a_pt;

    always_comb begin
        n_a_pt.x   = i_shock_x;
        n_a_pt.y   = i_shock_y;
        n_a_pt.ush = i_shock_vel_x;
        n_a_pt.vsh = i_shock_vel_y;
        n_a_pt.xi  = i_grid_x;
        n_a_pt.yi  = i_grid_y;
        n_a_pt.ui  = i_grid_vel_x;
        n_a_pt.vi  = i_grid_vel_y;
        n_a_pt.ai  = i_sound_speed;
    end

    always_ff @(posedge i_clk) begin
        r_a_pt <= n_a_pt;
        r_a_dx <= sat_sub(i_shock_x, i_grid_x);
        r_a_dy <= sat_sub(i_shock_y, i_grid_y);
    end

    // stage b: squares
    logic              r_b_vld;
    t_pt               r_b_pt;
    logic [2*DW-1:0]   r_b_sq [4];

    always_ff @(posedge i_clk) begin
        r_b_pt    <= r_a_pt;
        r_b_sq[0] <= mag(r_a_dx) * mag(r_a_dx);
        r_b_sq[1] <= mag(r_a_dy) * mag(r_a_dy);
        r_b_sq[2] <= mag(r_a_pt.ui) * mag(r_a_pt.ui);
        r_b_sq[3] <= mag(r_a_pt.vi) * mag(r_a_pt.vi);
    end

    // stage c: sums of squares
    logic            r_c_vld;
    t_pt             r_c_pt;
    logic [2*DW-1:0] r_c_rad0, r_c_rad1;

    always_ff @(posedge i_clk) begin
        r_c_pt   <= r_b_pt;
        r_c_rad0 <= r_b_sq[0] + r_b_sq[1];
        r_c_rad1 <= r_b_sq[2] + r_b_sq[3];
    end

    logic [DW-1:0] root_rl, root_gm;

    spdt_sqrt u_sqrt_rl (.i_clk(i_clk), .i_rad(r_c_rad0), .o_root(root_rl));
    spdt_sqrt u_sqrt_gm (.i_clk(i_clk), .i_rad(r_c_rad1), .o_root(root_gm));

    t_pt  r_s1_pt  [SQRT_LAT];
    logic r_s1_vld [SQRT_LAT];

    always_ff @(posedge i_clk) begin
        r_s1_pt[0] <= r_c_pt;
        for (int k = 1; k < SQRT_LAT; k++) begin
            r_s1_pt[k] <= r_s1_pt[k-1];
        end
    end

    // stage d: distance and denominator
    logic            r_d_vld;
    t_pt             r_d_pt;
    logic [DT_W-1:0] r_d_rl, r_d_den;
    logic [DT_W:0]   n_d_sum;

    assign n_d_sum = {1'b0, r_s1_pt[SQRT_LAT-1].ai} + {1'b0, clamp_root(root_gm)};

    always_ff @(posedge i_clk) begin
        r_d_pt  <= r_s1_pt[SQRT_LAT-1];
        r_d_rl  <= clamp_root(root_rl);
        r_d_den <= n_d_sum[DT_W] ? {DT_W{1'b1}} : n_d_sum[DT_W-1:0];
    end

    // stage e: divider operands
    logic             r_e_vld;
    t_mid             r_e_mid;
    logic [NUM_W-1:0] r_e_num;
    logic [DD_W-1:0]  r_e_dd;

    always_ff @(posedge i_clk) begin
        r_e_mid.pt   <= r_d_pt;
        r_e_mid.rl   <= r_d_rl;
        r_e_mid.zero <= r_d_den == '0;
        r_e_num      <= {1'b0, r_d_rl, {FRAC_BITS{1'b0}}};
        r_e_dd       <= DD_W'(r_d_den) * DD_W'(DT_SCALE);
    end

    logic [DT_W-1:0] dt;

    spdt_div u_div (.i_clk(i_clk), .i_num(r_e_num), .i_den(r_e_dd), .o_quo(dt));

    t_mid r_s2_mid [DIV_LAT];
    logic r_s2_vld [DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_s2_mid[0] <= r_e_mid;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_s2_mid[k] <= r_s2_mid[k-1];
        end
    end

    // stage f: products with dt
    logic               r_f_vld;
    t_mid               r_f_mid;
    logic [DW+DT_W-1:0] r_f_p [5];
    logic [4:0]         r_f_neg;
    t_mid               w_f_in;

    assign w_f_in = r_s2_mid[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        r_f_mid  <= w_f_in;
        r_f_p[0] <= mag(w_f_in.pt.ush) * dt;
        r_f_p[1] <= mag(w_f_in.pt.vsh) * dt;
        r_f_p[2] <= mag(w_f_in.pt.ui) * dt;
        r_f_p[3] <= mag(w_f_in.pt.vi) * dt;
        r_f_p[4] <= w_f_in.pt.ai * dt;
        r_f_neg  <= {1'b0, w_f_in.pt.vi[DW-1], w_f_in.pt.ui[DW-1],
                     w_f_in.pt.vsh[DW-1], w_f_in.pt.ush[DW-1]};
    end

    // stage g: rounding
    logic                 r_g_vld;
    t_mid                 r_g_mid;
    logic signed [DW-1:0] r_g_q [5];

    always_ff @(posedge i_clk) begin
        r_g_mid <= r_f_mid;
        for (int k = 0; k < 5; k++) begin
            r_g_q[k] <= qround(r_f_p[k], r_f_neg[k]);
        end
    end

    // stage h: advanced points
    logic                 r_h_vld;
    t_tail                r_h_tail;
    logic signed [DW-1:0] r_h_xx, r_h_yy, r_h_xxi, r_h_yyi;

    always_ff @(posedge i_clk) begin
        r_h_tail.rl   <= r_g_mid.rl;
        r_h_tail.pa   <= r_g_q[4];
        r_h_tail.zero <= r_g_mid.zero;
        r_h_xx        <= sat_add(r_g_mid.pt.x, r_g_q[0]);
        r_h_yy        <= sat_add(r_g_mid.pt.y, r_g_q[1]);
        r_h_xxi       <= sat_add(r_g_mid.pt.xi, r_g_q[2]);
        r_h_yyi       <= sat_add(r_g_mid.pt.yi, r_g_q[3]);
    end

    // stage i: advanced differences
    logic                 r_i_vld;
    t_tail                r_i_tail;
    logic signed [DW-1:0] r_i_dx, r_i_dy;

    always_ff @(posedge i_clk) begin
        r_i_tail <= r_h_tail;
        r_i_dx   <= sat_sub(r_h_xx, r_h_xxi);
        r_i_dy   <= sat_sub(r_h_yy, r_h_yyi);
    end

    // stage j: squares
    logic            r_j_vld;
    t_tail           r_j_tail;
    logic [2*DW-1:0] r_j_sx, r_j_sy;

    always_ff @(posedge i_clk) begin
        r_j_tail <= r_i_tail;
        r_j_sx   <= mag(r_i_dx) * mag(r_i_dx);
        r_j_sy   <= mag(r_i_dy) * mag(r_i_dy);
    end

    // stage k: sum
    logic            r_k_vld;
    t_tail           r_k_tail;
    logic [2*DW-1:0] r_k_rad;

    always_ff @(posedge i_clk) begin
        r_k_tail <= r_j_tail;
        r_k_rad  <= r_j_sx + r_j_sy;
    end

    logic [DW-1:0] root_adv;

    spdt_sqrt u_sqrt_adv (.i_clk(i_clk), .i_rad(r_k_rad), .o_root(root_adv));

    t_tail r_s3_tail [SQRT_LAT];
    logic  r_s3_vld  [SQRT_LAT];

    always_ff @(posedge i_clk) begin
        r_s3_tail[0] <= r_k_tail;
        for (int k = 1; k < SQRT_LAT; k++) begin
            r_s3_tail[k] <= r_s3_tail[k-1];
        end
    end

    // stage l: final compare
    t_tail                w_l_in;
    logic signed [DW-1:0] n_dsh2;

    assign w_l_in = r_s3_tail[SQRT_LAT-1];
    assign n_dsh2 = sat_sub($signed({1'b0, clamp_root(root_adv)}), w_l_in.pa);

    always_ff @(posedge i_clk) begin
        o_zero_speed_fault <= w_l_in.zero;
        o_dependent        <= !w_l_in.zero && (n_dsh2 < $signed({1'b0, w_l_in.rl}));
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
            o_done  <= 1'b0;
            for (int k = 0; k < SQRT_LAT; k++) begin
                r_s1_vld[k] <= 1'b0;
                r_s3_vld[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_LAT; k++) begin
                r_s2_vld[k] <= 1'b0;
            end
        end else begin
            r_a_vld     <= accept;
            r_b_vld     <= r_a_vld;
            r_c_vld     <= r_b_vld;
            r_s1_vld[0] <= r_c_vld;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_s1_vld[k] <= r_s1_vld[k-1];
                r_s3_vld[k] <= r_s3_vld[k-1];
            end
            r_d_vld     <= r_s1_vld[SQRT_LAT-1];
            r_e_vld     <= r_d_vld;
            r_s2_vld[0] <= r_e_vld;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_s2_vld[k] <= r_s2_vld[k-1];
            end
            r_f_vld     <= r_s2_vld[DIV_LAT-1];
            r_g_vld     <= r_f_vld;
            r_h_vld     <= r_g_vld;
            r_i_vld     <= r_h_vld;
            r_j_vld     <= r_i_vld;
            r_k_vld     <= r_j_vld;
            r_s3_vld[0] <= r_k_vld;
            o_done      <= r_s3_vld[SQRT_LAT-1];
        end
    end

    // every accepted transaction produces its strobe after the full pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##PIPE_LAT o_done)
        else $error("result strobe missing after pipeline latency");

    a_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_zero_speed_fault |-> !o_dependent)
        else $error("dependence reported with zero denominator");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_vld && r_e_mid.zero |-> r_e_dd == '0)
        else $error("fault flag set with nonzero scaled denominator");

    a_fault_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld && r_d_den == '0 |-> r_d_pt.ai == '0)
        else $error("zero denominator with nonzero sound speed");

endmodule
